/* rtl/core/sram_walking_bit_tester_defines.svh */
// Assertion macros for the walking-bit memory tester checker.
// Needs a clk and an active-low arst_n in the scope of use.
`ifndef SRAM_WALKING_BIT_TESTER_DEFINES_SVH
`define SRAM_WALKING_BIT_TESTER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define SWBT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet during reset.
`define SWBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/swbt_pkg.sv */
// Shared types and constants for the walking-bit memory tester.
// No dependencies; used by the register file, step logic and top level.
`timescale 1ns / 1ps

package swbt_pkg;

	localparam int ADDR_W   = 16;
	localparam int SIZE_W   = 11;
	localparam int FAULT_W  = 32;
	localparam int BYTES_W  = 11;
	localparam int BITS_W   = 14;
	localparam int OUT_W    = 96;
	localparam int CMP_W    = 17;
	localparam int PADDR_W  = 4;

	localparam logic [1:0] REG_BASE = 2'd0;
	localparam logic [1:0] REG_SIZE = 2'd1;
	localparam logic [1:0] REG_BIT6 = 2'd2;
	localparam logic [1:0] REG_MODE = 2'd3;

	localparam logic [ADDR_W-1:0] BASE_RESET = 16'h3C00;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic [7:0] FILL_ZEROS = 8'h00;
	localparam logic [7:0] FILL_ONES  = 8'hFF;
	localparam logic [7:0] LANES_ALL  = 8'hFF;
	localparam logic [7:0] LANES_NO6  = 8'hBF;
	localparam logic [2:0] LANE6      = 3'd6;
	localparam logic [2:0] BIT_LOW    = 3'd0;
	localparam logic [2:0] BIT_HIGH   = 3'd7;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FILL,
		PH_TREAD,
		PH_TWRITE,
		PH_SCAN,
		PH_RESTORE,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_TARGET,
		PEND_SCAN
	} pend_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
		logic              bit6;
		logic              mode;
	} run_t;

	typedef struct packed {
		logic [FAULT_W-1:0] fault_total;
		logic [7:0]         lane_failures;
		logic [BYTES_W-1:0] byte_total;
		logic [BITS_W-1:0]  bit_total;
	} stats_t;

	typedef struct packed {
		logic [ADDR_W-1:0] mem_address;
		logic              mem_write;
		logic [7:0]        write_data;
		logic              done_res;
	} cmd_t;

endpackage

/* rtl/core/swbt_regs.sv */
// APB configuration registers of the walking-bit memory tester.
// Depends on swbt_pkg for register codes and reset values.
`timescale 1ns / 1ps

module swbt_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swbt_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output swbt_pkg::run_t                cfg
);

	logic          wr_en;
	logic [1:0]    reg_idx;
	swbt_pkg::run_t cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base <= swbt_pkg::BASE_RESET;
			cfg_q.size <= swbt_pkg::SIZE_RESET;
			cfg_q.bit6 <= 1'b1;
			cfg_q.mode <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				swbt_pkg::REG_BASE: cfg_q.base <= pwdata[swbt_pkg::ADDR_W-1:0];
				swbt_pkg::REG_SIZE: cfg_q.size <= pwdata[swbt_pkg::SIZE_W-1:0];
				swbt_pkg::REG_BIT6: cfg_q.bit6 <= pwdata[0];
				swbt_pkg::REG_MODE: cfg_q.mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			swbt_pkg::REG_BASE: prdata = 32'(cfg_q.base);
			swbt_pkg::REG_SIZE: prdata = 32'(cfg_q.size);
			swbt_pkg::REG_BIT6: prdata = 32'(cfg_q.bit6);
			swbt_pkg::REG_MODE: prdata = 32'(cfg_q.mode);
			default:            prdata = '0;
		endcase
	end

endmodule

/* rtl/core/swbt_step.sv */
// Next-state and command logic for one step of the walking-bit sequencer.
// Purely combinational; depends on swbt_pkg.
`timescale 1ns / 1ps

module swbt_step #(
	parameter int MAX_REGION_BYTES = 1024,
	localparam int OFF_W = (MAX_REGION_BYTES > 1) ? $clog2(MAX_REGION_BYTES) : 1
) (
	input  logic                 op,
	input  logic [7:0]           rd,
	input  swbt_pkg::run_t       cfg,
	input  swbt_pkg::run_t       run,
	input  swbt_pkg::phase_t     phase,
	input  swbt_pkg::pend_t      pend,
	input  logic [OFF_W-1:0]     tgt,
	input  logic [2:0]           bitp,
	input  logic [OFF_W-1:0]     scan,
	input  logic [7:0]           saved,
	input  swbt_pkg::stats_t     stats,
	output swbt_pkg::run_t       run_n,
	output swbt_pkg::phase_t     phase_n,
	output swbt_pkg::pend_t      pend_n,
	output logic [OFF_W-1:0]     tgt_n,
	output logic [2:0]           bitp_n,
	output logic [OFF_W-1:0]     scan_n,
	output logic [7:0]           saved_n,
	output swbt_pkg::stats_t     stats_n,
	output swbt_pkg::cmd_t       cmd
);

	localparam int CW = swbt_pkg::CMP_W;

	always_comb begin
		logic [swbt_pkg::SIZE_W-1:0] size_eff;
		logic [7:0]                  allowed;
		logic [7:0]                  rel;
		logic [7:0]                  bad;
		logic [7:0]                  m;
		logic [3:0]                  nbad;
		logic [swbt_pkg::FAULT_W:0]  fsum;
		logic [2:0]                  first_b;
		logic [2:0]                  nb;
		logic                        wrap;
		logic [OFF_W-1:0]            last_off;

		// latch configuration at start, clamping the region size
		size_eff = (cfg.size == '0) ? swbt_pkg::SIZE_W'(1) : cfg.size;
		if (CW'(size_eff) > CW'(MAX_REGION_BYTES))
			size_eff = swbt_pkg::SIZE_W'(MAX_REGION_BYTES);

		run_n   = run;
		phase_n = phase;
		pend_n  = pend;
		tgt_n   = tgt;
		bitp_n  = bitp;
		scan_n  = scan;
		saved_n = saved;
		stats_n = stats;
		bad     = '0;
		rel     = '0;
		cmd     = '0;
		allowed = '0;
		nb      = '0;
		wrap    = 1'b0;

		if (op == swbt_pkg::OP_START) begin
			run_n.base = cfg.base;
			run_n.size = size_eff;
			run_n.bit6 = cfg.bit6;
			run_n.mode = cfg.mode;
			phase_n    = swbt_pkg::PH_FILL;
			pend_n     = swbt_pkg::PEND_NONE;
			tgt_n      = '0;
			bitp_n     = '0;
			scan_n     = '0;
			saved_n    = '0;
			stats_n    = '0;
		end else begin
			allowed = run.bit6 ? swbt_pkg::LANES_ALL : swbt_pkg::LANES_NO6;
			case (pend)
				swbt_pkg::PEND_TARGET: begin
					rel     = (8'd1 << bitp) & allowed;
					saved_n = rd;
				end
				swbt_pkg::PEND_SCAN: begin
					rel = allowed;
					if (scan == tgt)
						rel = rel & ~(8'd1 << bitp);
					// step the scan pointer, or end the scan at the region edge
					if (run.mode) begin
						if (scan == '0)
							phase_n = swbt_pkg::PH_RESTORE;
						else
							scan_n = scan - OFF_W'(1);
					end else begin
						if ((CW'(scan) + CW'(1)) >= CW'(run.size))
							phase_n = swbt_pkg::PH_RESTORE;
						else
							scan_n = scan + OFF_W'(1);
					end
				end
				default: rel = '0;
			endcase
			bad = run.mode ? (~rd & rel) : (rd & rel);
			pend_n = swbt_pkg::PEND_NONE;
		end

		nbad = '0;
		for (int i = 0; i < 8; i++)
			nbad = nbad + 4'(bad[i]);
		fsum = {1'b0, stats_n.fault_total} + (swbt_pkg::FAULT_W + 1)'(nbad);
		stats_n.fault_total   = fsum[swbt_pkg::FAULT_W] ? '1 :
			fsum[swbt_pkg::FAULT_W-1:0];
		stats_n.lane_failures = stats_n.lane_failures | bad;

		first_b  = run_n.mode ? swbt_pkg::BIT_HIGH : swbt_pkg::BIT_LOW;
		last_off = OFF_W'(run_n.size - swbt_pkg::SIZE_W'(1));
		m        = 8'd1 << bitp_n;

		case (phase_n)
			swbt_pkg::PH_FILL: begin
				cmd.mem_address = run_n.base + swbt_pkg::ADDR_W'(scan_n);
				cmd.mem_write   = 1'b1;
				cmd.write_data  = run_n.mode ? swbt_pkg::FILL_ONES : swbt_pkg::FILL_ZEROS;
				if ((CW'(scan_n) + CW'(1)) >= CW'(run_n.size)) begin
					phase_n = swbt_pkg::PH_TREAD;
					tgt_n   = run_n.mode ? last_off : '0;
					bitp_n  = first_b;
					scan_n  = '0;
				end else begin
					scan_n = scan_n + OFF_W'(1);
				end
			end
			swbt_pkg::PH_TREAD: begin
				cmd.mem_address = run_n.base + swbt_pkg::ADDR_W'(tgt_n);
				if (bitp_n == first_b && stats_n.byte_total != '1)
					stats_n.byte_total = stats_n.byte_total + swbt_pkg::BYTES_W'(1);
				if (stats_n.bit_total != '1)
					stats_n.bit_total = stats_n.bit_total + swbt_pkg::BITS_W'(1);
				pend_n  = swbt_pkg::PEND_TARGET;
				phase_n = swbt_pkg::PH_TWRITE;
			end
			swbt_pkg::PH_TWRITE: begin
				cmd.mem_address = run_n.base + swbt_pkg::ADDR_W'(tgt_n);
				cmd.mem_write   = 1'b1;
				cmd.write_data  = run_n.mode ? (saved_n & ~m) : m;
				scan_n          = run_n.mode ? last_off : '0;
				phase_n         = swbt_pkg::PH_SCAN;
			end
			swbt_pkg::PH_SCAN: begin
				cmd.mem_address = run_n.base + swbt_pkg::ADDR_W'(scan_n);
				pend_n          = swbt_pkg::PEND_SCAN;
			end
			swbt_pkg::PH_RESTORE: begin
				cmd.mem_address = run_n.base + swbt_pkg::ADDR_W'(tgt_n);
				cmd.mem_write   = 1'b1;
				cmd.write_data  = run_n.mode ? (saved_n | m) : swbt_pkg::FILL_ZEROS;
				// next bit in walk order, skipping lane 6 when disabled
				if (run_n.mode) begin
					wrap = (bitp_n == swbt_pkg::BIT_LOW);
					nb   = bitp_n - 3'd1;
				end else begin
					wrap = (bitp_n == swbt_pkg::BIT_HIGH);
					nb   = bitp_n + 3'd1;
				end
				if (nb == swbt_pkg::LANE6 && !run_n.bit6)
					nb = run_n.mode ? (nb - 3'd1) : (nb + 3'd1);
				phase_n = swbt_pkg::PH_TREAD;
				if (!wrap) begin
					bitp_n = nb;
				end else if (run_n.mode) begin
					if (tgt_n == '0) begin
						phase_n = swbt_pkg::PH_DONE;
					end else begin
						tgt_n  = tgt_n - OFF_W'(1);
						bitp_n = first_b;
					end
				end else begin
					if ((CW'(tgt_n) + CW'(1)) >= CW'(run_n.size)) begin
						phase_n = swbt_pkg::PH_DONE;
					end else begin
						tgt_n  = tgt_n + OFF_W'(1);
						bitp_n = first_b;
					end
				end
			end
			default: cmd.done_res = 1'b1;
		endcase
	end

endmodule

/* rtl/core/sram_walking_bit_tester.sv */
// Walking-bit memory self-test sequencer, top level.
// Depends on swbt_pkg, swbt_regs and swbt_step.
`timescale 1ns / 1ps

// Usage:
//  Slave stream s_*: one item per memory step. s_tuser is the op (0 starts a
//  run and latches the configuration, 1 advances one step); s_tdata carries the
//  byte read back for the read command issued by the previous result.
//  Master stream m_*: one result per accepted item, holding the command to
//  issue (address, write flag, write data), the done flag and the running
//  fault, lane, byte and bit statistics.
//  APB port: base address, region size, lane 6 enable and pattern mode at byte
//  addresses 0, 4, 8 and 12; changes apply at the next start.
//  Output: a result appears on m_tvalid in the cycle after its item is accepted.
//  Throughput: one item per cycle unless m_tready stalls the output; the whole
//  step is resolved between the sequencer state registers and the output register.
//  Reset: the sequencer goes idle and every advance reports done until a start.
//  Stall: while m_tready is low with a result waiting, s_tready drops and the
//  result holds; an item is still taken in the cycle the result is drained.
module sram_walking_bit_tester #(
	parameter int MAX_REGION_BYTES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swbt_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] read_data
	input  logic                          s_tuser,  // [0] op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] mem_address, [16] mem_write, [24:17] write_data, [25] done_res,
	// [57:26] fault_count, [65:58] lane_fail_mask, [76:66] bytes_tested,
	// [90:77] bits_tested, [95:91] zero
	output logic [swbt_pkg::OUT_W-1:0]    m_tdata
);

	localparam int OFF_W = (MAX_REGION_BYTES > 1) ? $clog2(MAX_REGION_BYTES) : 1;
	localparam int PAD_W = swbt_pkg::OUT_W - 91;

	swbt_pkg::run_t   cfg;
	swbt_pkg::run_t   run_q, run_n;
	swbt_pkg::phase_t phase_q, phase_n;
	swbt_pkg::pend_t  pend_q, pend_n;
	logic [OFF_W-1:0] tgt_q, tgt_n;
	logic [OFF_W-1:0] scan_q, scan_n;
	logic [2:0]       bitp_q, bitp_n;
	logic [7:0]       saved_q, saved_n;
	swbt_pkg::stats_t stats_q, stats_n;
	swbt_pkg::cmd_t   cmd;

	logic                       s_fire;
	logic                       m_tvalid_q;
	logic [swbt_pkg::OUT_W-1:0] m_tdata_q;

	swbt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swbt_step #(
		.MAX_REGION_BYTES (MAX_REGION_BYTES)
	) u_step (
		.op      (s_tuser),
		.rd      (s_tdata),
		.cfg     (cfg),
		.run     (run_q),
		.phase   (phase_q),
		.pend    (pend_q),
		.tgt     (tgt_q),
		.bitp    (bitp_q),
		.scan    (scan_q),
		.saved   (saved_q),
		.stats   (stats_q),
		.run_n   (run_n),
		.phase_n (phase_n),
		.pend_n  (pend_n),
		.tgt_n   (tgt_n),
		.bitp_n  (bitp_n),
		.scan_n  (scan_n),
		.saved_n (saved_n),
		.stats_n (stats_n),
		.cmd     (cmd)
	);

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q.base <= '0;
			run_q.size <= swbt_pkg::SIZE_W'(1);
			run_q.bit6 <= 1'b1;
			run_q.mode <= 1'b0;
			phase_q    <= swbt_pkg::PH_IDLE;
			pend_q     <= swbt_pkg::PEND_NONE;
			tgt_q      <= '0;
			scan_q     <= '0;
			bitp_q     <= '0;
			saved_q    <= '0;
			stats_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				run_q   <= run_n;
				phase_q <= phase_n;
				pend_q  <= pend_n;
				tgt_q   <= tgt_n;
				scan_q  <= scan_n;
				bitp_q  <= bitp_n;
				saved_q <= saved_n;
				stats_q <= stats_n;
			end
			// hold the result until taken
			if (s_fire)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			m_tdata_q <= {{PAD_W{1'b0}}, stats_n.bit_total, stats_n.byte_total,
				stats_n.lane_failures, stats_n.fault_total, cmd.done_res,
				cmd.write_data, cmd.mem_write, cmd.mem_address};
	end

endmodule

/* rtl/core/swbt_checker.sv */
// Port-level checks for the walking-bit memory tester, bound to the top level.
// Depends on sram_walking_bit_tester_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "sram_walking_bit_tester_defines.svh"

module swbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	// a done result issues no command
	`SWBT_ASSERT_NOW(a_done_idle, m_tvalid && m_tdata[25], !m_tdata[16] && m_tdata[15:0] == 16'd0 && m_tdata[24:17] == 8'd0, "done result carries a command")

	// a start gives a fill write with all statistics cleared
	`SWBT_ASSERT_NEXT(a_start_clears, s_tvalid && s_tready && !s_tuser, m_tvalid && m_tdata[16] && !m_tdata[25] && m_tdata[90:26] == 65'd0, "start did not clear statistics")

	// every accepted item yields a result in the next cycle
	`SWBT_ASSERT_NEXT(a_item_result, s_tvalid && s_tready, m_tvalid, "accepted item gave no result")

	// a stalled result holds
	`SWBT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind sram_walking_bit_tester swbt_checker u_swbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
